/* rtl/core/nnq_pkg.sv */
package nnq_pkg;

    localparam int TABLE_DEPTH    = 256;
    localparam int COMPONENT_BITS = 15;
    localparam int NUM_COMP       = 3;

    // fixed field widths
    localparam int COMP_W  = 16;
    localparam int INDEX_W = 8;
    localparam int CFG_W   = 9;
    localparam int DIST_W  = 32;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    // clamped component spans -2^(CB-1) .. +2^(CB-1)
    localparam int STORE_W = COMPONENT_BITS + 1;
    localparam int DIFF_W  = STORE_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int ACC_W   = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
    localparam int CLAMP_W = ((COMP_W > STORE_W) ? COMP_W : STORE_W) + 1;

    localparam logic [DIST_W-1:0] DIST_MAX          = '1;
    localparam logic [CFG_W-1:0]  ENTRY_COUNT_RESET = 9'd162;

    // register index codes
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // input op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [DIST_W-1:0] sum;
    } link_t;

    function automatic logic signed [STORE_W-1:0] clamp_comp(input logic [COMP_W-1:0] raw);
        logic signed [CLAMP_W-1:0] v;
        logic signed [CLAMP_W-1:0] lim;
        v = {{(CLAMP_W - COMP_W){raw[COMP_W-1]}}, raw};
        lim = '0;
        lim[COMPONENT_BITS-1] = 1'b1;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[STORE_W-1:0];
    endfunction

endpackage

/* rtl/core/nearest_normal_quantizer.sv */
// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ------------------------------------
// in       sink       in_valid / in_stall    op, entry_index, vec_x, vec_y, vec_z
// out      source     out_valid / out_stall  best_index
// cfg      sink       APB psel / penable     paddr, pwdata, prdata (entry_count)
//
// A load word writes all three component cells at once.
// A query scans one entry per cycle through a chain of three cells (x, y, z),
// each three stages deep: with n entries searched (entry_count, at least 1,
// at most 256) the result enters the output register once the last entry has
// passed all three cells and the tracker and the output register is free.
// Reset clears control state and sets entry_count to 162; the table holds
// nothing until loaded. in_stall stays high through a scan; the result is
// held in the output register while out_stall is high, and the next word is
// accepted as soon as the result sits there.
module nearest_normal_quantizer
    import nnq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [COMP_W-1:0]  vec_x,
    input  logic [COMP_W-1:0]  vec_y,
    input  logic [COMP_W-1:0]  vec_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] best_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CFG_W-1:0] count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             issue_reg, issue_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] limit_reg, limit_next;

    logic             accept;
    logic             query_acc;
    logic             load_acc;
    logic             cfg_wr;
    logic             done;
    logic [CFG_W-1:0] span;

    logic signed [STORE_W-1:0] comp [NUM_COMP];
    link_t                     chain [NUM_COMP+1];

    assign accept    = in_valid && !busy_reg;
    assign query_acc = accept && (op == OP_QUERY);
    assign load_acc  = accept && (op == OP_LOAD)
                       && ({1'b0, entry_index} < (INDEX_W + 1)'(TABLE_DEPTH));
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);

    assign comp[0] = clamp_comp(vec_x);
    assign comp[1] = clamp_comp(vec_y);
    assign comp[2] = clamp_comp(vec_z);

    // entries searched: at least one, at most the table
    always_comb
    begin
        if (count_reg == '0)
            span = CFG_W'(1);
        else if (count_reg > CFG_W'(TABLE_DEPTH))
            span = CFG_W'(TABLE_DEPTH);
        else
            span = count_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        issue_next = issue_reg;
        pos_next   = pos_reg;
        limit_next = limit_reg;

        if (cfg_wr)
            count_next = pwdata[CFG_W-1:0];

        if (query_acc)
        begin
            busy_next  = 1'b1;
            issue_next = 1'b1;
            pos_next   = '0;
            limit_next = CNT_W'(span - CFG_W'(1));
        end
        else if (issue_reg)
        begin
            pos_next = pos_reg + CNT_W'(1);
            if (pos_reg == limit_reg)
                issue_next = 1'b0;
        end

        if (done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= ENTRY_COUNT_RESET;
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            pos_reg   <= '0;
            limit_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            issue_reg <= issue_next;
            pos_reg   <= pos_next;
            limit_reg <= limit_next;
        end
    end

    assign chain[0].valid = issue_reg;
    assign chain[0].first = (pos_reg == '0);
    assign chain[0].last  = (pos_reg == limit_reg);
    assign chain[0].addr  = pos_reg[ADDR_W-1:0];
    assign chain[0].sum   = '0;

    for (genvar k = 0; k < NUM_COMP; k++)
    begin : g_cell
        nnq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (load_acc),
            .wr_addr  (entry_index[ADDR_W-1:0]),
            .wr_data  (comp[k]),
            .q_load   (query_acc),
            .q_data   (comp[k]),
            .link_in  (chain[k]),
            .link_out (chain[k+1])
        );
    end

    nnq_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_in    (chain[NUM_COMP]),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .best_index (best_index),
        .done       (done)
    );

    assign in_stall = busy_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_ENTRY_COUNT) ? 32'(count_reg) : 32'd0;

endmodule

/* rtl/core/nnq_cell.sv */
module nnq_cell
    import nnq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [STORE_W-1:0] wr_data,
    input  logic                      q_load,
    input  logic signed [STORE_W-1:0] q_data,
    input  link_t                     link_in,
    output link_t                     link_out
);

    logic signed [STORE_W-1:0] mem [TABLE_DEPTH];

    logic signed [STORE_W-1:0] q_reg;
    logic signed [STORE_W-1:0] rd_reg;
    logic [SQ_W-1:0]           sq_reg;
    link_t                     s1_reg;
    link_t                     s2_reg;
    link_t                     out_reg;
    link_t                     out_next;

    logic signed [DIFF_W-1:0] diff;
    logic signed [SQ_W-1:0]   sq_full;
    logic [ACC_W-1:0]         acc;

    assign diff    = DIFF_W'(q_reg) - DIFF_W'(rd_reg);
    assign sq_full = diff * diff;
    assign acc     = ACC_W'(s2_reg.sum) + ACC_W'(sq_reg);

    always_comb
    begin
        out_next = s2_reg;
        // saturate the running distance
        if (acc > ACC_W'(DIST_MAX))
            out_next.sum = DIST_MAX;
        else
            out_next.sum = acc[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (q_load)
            q_reg <= q_data;
        rd_reg <= mem[link_in.addr];
        sq_reg <= sq_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            out_reg <= '0;
        end
        else
        begin
            s1_reg  <= link_in;
            s2_reg  <= s1_reg;
            out_reg <= out_next;
        end
    end

    assign link_out = out_reg;

endmodule

/* rtl/core/nnq_track.sv */
module nnq_track
    import nnq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  link_t              link_in,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [INDEX_W-1:0] best_index,
    output logic               done
);

    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [ADDR_W-1:0]  best_slot_reg, best_slot_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic               out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_slot_next = best_slot_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        done           = 1'b0;

        // the first entry seeds; strict less-than keeps the lowest index
        if (link_in.valid)
        begin
            if (link_in.first || (link_in.sum < best_dist_reg))
            begin
                best_dist_next = link_in.sum;
                best_slot_next = link_in.addr;
            end
            if (link_in.last)
                pend_next = 1'b1;
        end

        if (pend_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_index_next = INDEX_W'(best_slot_reg);
            pend_next      = 1'b0;
            done           = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= '0;
            best_slot_reg <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            best_dist_reg <= best_dist_next;
            best_slot_reg <= best_slot_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
    end

    assign out_valid  = out_valid_reg;
    assign best_index = out_index_reg;

endmodule

/* rtl/core/nnq_checker.sv */
module nnq_checker
    import nnq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               op,
    input logic               out_valid,
    input logic               out_stall,
    input logic [INDEX_W-1:0] best_index
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_index))
        else $error("result changed while stalled");

    // a query locks the input until its result is out
    a_query_locks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_QUERY) |=> in_stall)
        else $error("input open during scan");

    // a result only appears at the end of a scan
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without scan");

    // input reopens together with the result
    a_release_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("input released without result");

endmodule

bind nearest_normal_quantizer nnq_checker u_nnq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_index (best_index)
);

/* verif/nearest_normal_quantizer_tb.sv */
`timescale 1ns / 1ps

module nearest_normal_quantizer_tb;
    import nnq_pkg::*;

    localparam int          CYCLE_LIMIT      = 1000000;
    localparam int          SETTLE_CYCLES    = 16;
    localparam int          END_CYCLES       = 300;
    localparam int          BLOCK_WORDS      = 23;
    localparam logic [2:0]  ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               op          = OP_LOAD;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [COMP_W-1:0]  vec_x       = '0;
    logic [COMP_W-1:0]  vec_y       = '0;
    logic [COMP_W-1:0]  vec_z       = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [INDEX_W-1:0] best_index;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [2:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state
    int                 normal_x [TABLE_DEPTH];
    int                 normal_y [TABLE_DEPTH];
    int                 normal_z [TABLE_DEPTH];
    logic [CFG_W-1:0]   entry_count_setting = ENTRY_COUNT_RESET;
    logic [INDEX_W-1:0] expected_index [$];

    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 hold_len       = 0;
    logic               holding        = 1'b0;
    event               start_hold;

    int                 errors          = 0;
    int                 loads_sent      = 0;
    int                 queries_sent    = 0;
    int                 results_checked = 0;
    int                 count_writes    = 0;
    int                 cycle_count     = 0;

    nearest_normal_quantizer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_index  (best_index),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     expected_index.size());
            $display("status: fail");
            $finish;
        end
    end

    // output stall: random, or held high for a long stretch on request
    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < recv_stall_pct);

    initial
    begin
        forever
        begin
            @(start_hold);
            holding <= 1'b1;
            repeat (hold_len) @(posedge clk);
            holding <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (expected_index.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual best_index %0d",
                         $time, best_index);
                errors++;
            end
            else if (best_index !== expected_index[0])
            begin
                $display("%0t: best_index mismatch: expected %0d, actual %0d",
                         $time, expected_index[0], best_index);
                errors++;
                void'(expected_index.pop_front());
            end
            else
                void'(expected_index.pop_front());
        end
    end

    function automatic int clamp_component(input logic [COMP_W-1:0] raw);
        int lim;
        int v;
        lim = 1 << (COMPONENT_BITS - 1);
        v = $signed(raw);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic int scan_length();
        if (entry_count_setting == 0)
            return 1;
        if (entry_count_setting > TABLE_DEPTH)
            return TABLE_DEPTH;
        return entry_count_setting;
    endfunction

    function automatic longint distance_to(input int slot, input int qx, input int qy,
                                           input int qz);
        longint dx;
        longint dy;
        longint dz;
        longint sum;
        dx = qx - normal_x[slot];
        dy = qy - normal_y[slot];
        dz = qz - normal_z[slot];
        sum = dx * dx + dy * dy + dz * dz;
        if (sum > longint'(DIST_MAX))
            sum = longint'(DIST_MAX);
        return sum;
    endfunction

    function automatic logic [INDEX_W-1:0] nearest_slot(input int qx, input int qy,
                                                        input int qz);
        int     n;
        int     i;
        int     best;
        longint d;
        longint best_d;
        n = scan_length();
        best = 0;
        best_d = distance_to(0, qx, qy, qz);
        for (i = 1; i < n; i++)
        begin
            d = distance_to(i, qx, qy, qz);
            // strict less-than: lowest slot wins a tie
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        return best[INDEX_W-1:0];
    endfunction

    function automatic logic [COMP_W-1:0] random_component();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return COMP_W'(int'($urandom_range(32768)) - 16384);
        if (r < 80)
        begin
            case ($urandom_range(3))
                0: return 16'sd16384;
                1: return -16'sd16384;
                2: return 16'h7FFF;
                default: return 16'h8000;
            endcase
        end
        return COMP_W'($urandom);
    endfunction

    // offer one word, update the predictor when it is taken
    task automatic send_word(input logic word_op, input logic [INDEX_W-1:0] slot,
                             input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
                             input logic [COMP_W-1:0] z);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= word_op;
        entry_index <= slot;
        vec_x       <= x;
        vec_y       <= y;
        vec_z       <= z;
        do @(posedge clk); while (in_stall);
        if (word_op == OP_LOAD)
        begin
            normal_x[slot] = clamp_component(x);
            normal_y[slot] = clamp_component(y);
            normal_z[slot] = clamp_component(z);
            loads_sent++;
        end
        else
        begin
            expected_index.push_back(nearest_slot(clamp_component(x), clamp_component(y),
                                                  clamp_component(z)));
            queries_sent++;
        end
    endtask

    task automatic wait_for_results();
        while (expected_index.size() != 0)
            @(posedge clk);
    endtask

    // hold the sender until everything predicted has come back
    task automatic pause_input();
        in_valid <= 1'b0;
        wait_for_results();
        @(posedge clk);
    endtask

    // stop offering and wait until every predicted result has come back, then idle
    task automatic settle_idle();
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRY_COUNT;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        entry_count_setting = value;
        count_writes++;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(value))
        begin
            $display("%0t: entry_count readback mismatch: expected %0d, actual %0d",
                     $time, value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic query_copy_of(input int slot);
        send_word(OP_QUERY, INDEX_W'($urandom), COMP_W'(normal_x[slot]),
                  COMP_W'(normal_y[slot]), COMP_W'(normal_z[slot]));
    endtask

    // every slot written once so no query ever reads an empty entry
    task automatic test_table_fill();
        int i;
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        for (i = 0; i < TABLE_DEPTH; i++)
            send_word(OP_LOAD, INDEX_W'(i), random_component(), random_component(),
                      random_component());
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // reset count still in force
        query_copy_of(100);
        send_word(OP_LOAD, 8'd0, 16'sd16384, 16'sd16384, 16'sd16384);
        send_word(OP_LOAD, 8'd1, 16'sd16384, 16'sd16384, 16'sd16384);
        send_word(OP_LOAD, 8'd255, -16'sd16384, -16'sd16384, -16'sd16384);
        // out-of-range load clamps; slot 7 then ties with slot 5
        send_word(OP_LOAD, 8'd5, 16'h7FFF, 16'h8000, 16'sd16385);
        send_word(OP_LOAD, 8'd7, 16'sd16384, -16'sd16384, 16'sd16384);
        send_word(OP_QUERY, 8'hFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        // tie with the first entry
        send_word(OP_QUERY, 8'h00, 16'sd16000, 16'sd16384, 16'sd16384);
        settle_idle();
        write_entry_count(9'd0);
        send_word(OP_QUERY, 8'h00, -16'sd16384, -16'sd16384, -16'sd16384);
        settle_idle();
        write_entry_count(9'd1);
        send_word(OP_QUERY, 8'h00, -16'sd16384, -16'sd16384, -16'sd16384);
        settle_idle();
        write_entry_count(9'd255);
        send_word(OP_QUERY, 8'h00, -16'sd16384, -16'sd16384, -16'sd16384);
        settle_idle();
        write_entry_count(9'd256);
        send_word(OP_QUERY, 8'h00, -16'sd16384, -16'sd16384, -16'sd16384);
        settle_idle();
        write_entry_count(9'd257);
        send_word(OP_QUERY, 8'h00, 16'h8000, 16'h8000, 16'h8000);
        settle_idle();
        write_entry_count(9'd511);
        send_word(OP_QUERY, 8'h00, 16'h8001, 16'h8000, 16'hC000);
        query_copy_of(200);
    endtask

    task automatic test_backpressure();
        int i;
        settle_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_entry_count(9'd4);
        hold_len = 400;
        -> start_hold;
        // keep offering while the output is held: input must back up
        for (i = 0; i < 16; i++)
        begin
            if (i % 5 == 4)
                send_word(OP_LOAD, INDEX_W'($urandom_range(3)), random_component(),
                          random_component(), random_component());
            else
                query_copy_of($urandom_range(3));
        end
        pause_input();
        for (i = 0; i < 8; i++)
            send_word(OP_QUERY, INDEX_W'($urandom), random_component(), random_component(),
                      random_component());
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int words);
        int               k;
        int               n;
        int               r;
        int               j;
        logic [CFG_W-1:0] count;
        logic [INDEX_W-1:0] slot;
        for (k = 0; k < words; k++)
        begin
            if (k % BLOCK_WORDS == 0)
            begin
                settle_idle();
                send_idle_pct  = idle_pct;
                recv_stall_pct = stall_pct;
                // mostly short scans, now and then a full sweep or an odd count
                if ($urandom_range(99) < 85)
                    count = CFG_W'($urandom_range(1, 32));
                else
                begin
                    case ($urandom_range(3))
                        0: count = 9'd0;
                        1: count = 9'd256;
                        2: count = 9'd300;
                        default: count = 9'd511;
                    endcase
                end
                write_entry_count(count);
            end
            n = scan_length();
            r = $urandom_range(99);
            j = $urandom_range(n - 1);
            if ($urandom_range(1) == 1)
            begin
                if (r < 20)
                    query_copy_of(j);
                else if (r < 60)
                    send_word(OP_QUERY, INDEX_W'($urandom),
                              COMP_W'(normal_x[j] + int'($urandom_range(400)) - 200),
                              COMP_W'(normal_y[j] + int'($urandom_range(400)) - 200),
                              COMP_W'(normal_z[j] + int'($urandom_range(400)) - 200));
                else
                    send_word(OP_QUERY, INDEX_W'($urandom), random_component(),
                              random_component(), random_component());
            end
            else
            begin
                if ($urandom_range(99) < 60)
                    slot = INDEX_W'($urandom_range(n - 1));
                else
                    slot = INDEX_W'($urandom);
                // copies of other entries make ties
                if (r < 15)
                    send_word(OP_LOAD, slot, COMP_W'(normal_x[j]), COMP_W'(normal_y[j]),
                              COMP_W'(normal_z[j]));
                else
                    send_word(OP_LOAD, slot, random_component(), random_component(),
                              random_component());
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_directed();
        test_backpressure();
        test_random(0, 0, 115);
        test_random(63, 0, 115);
        test_random(0, 63, 115);
        test_random(29, 29, 115);

        in_valid <= 1'b0;
        wait_for_results();
        repeat (END_CYCLES) @(posedge clk);
        if (expected_index.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_index.size());
            errors++;
        end
        $display("covered %0d loads and %0d queries, %0d results checked, %0d count writes",
                 loads_sent, queries_sent, results_checked, count_writes);
        $display("counts 0 to 511, clamped components, ties, long output hold, %0d errors",
                 errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/nnq_pkg.sv
rtl/core/nnq_cell.sv
rtl/core/nnq_track.sv
rtl/core/nearest_normal_quantizer.sv
rtl/core/nnq_checker.sv
verif/nearest_normal_quantizer_tb.sv
